>>> hdl/nvrs_pkg.sv
`timescale 1ns / 1ps
// nvrs_pkg: types, constants and small helpers shared by the variable and row scaler.
// No dependencies.

package nvrs_pkg;

  localparam int MAX_VARS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int VAR_AW   = $clog2(MAX_VARS);
  localparam int ROW_AW   = $clog2(MAX_ROWS);

  // operation codes of an input request
  localparam logic [1:0] OP_VAR  = 2'd0;
  localparam logic [1:0] OP_ROW  = 2'd1;
  localparam logic [1:0] OP_JAC  = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  // row types
  localparam logic [1:0] TYPE_OBJ  = 2'd0;
  localparam logic [1:0] TYPE_EQ   = 2'd1;
  localparam logic [1:0] TYPE_INEQ = 2'd2;

  // floating point unit operations
  localparam logic [1:0] FOP_SUB = 2'd0;
  localparam logic [1:0] FOP_MUL = 2'd1;
  localparam logic [1:0] FOP_DIV = 2'd2;

  localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] EPS_BITS  = 64'h3E45_798E_E230_8C3A;  // 1.0e-8

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  item_index;
    logic [9:0]  col_index;
    logic [63:0] lower_bits;
    logic [63:0] upper_bits;
    logic [63:0] jac_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] var_gain;
    logic [63:0] var_offset;
    logic [1:0]  row_type;
    logic [63:0] row_gain;
  } out_item_t;

  typedef struct packed {
    logic var_ok;
    logic row_ok;
    logic col_ok;
    logic is_obj;
  } item_class_t;

  typedef struct packed {
    in_item_t    item;
    item_class_t cls;
  } q_entry_t;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fpu_rsp_t;

  function automatic logic f_is_nan(input logic [63:0] x);
    return (&x[62:52]) && (|x[51:0]);
  endfunction

  function automatic logic f_is_inf(input logic [63:0] x);
    return (&x[62:52]) && !(|x[51:0]);
  endfunction

  function automatic logic f_is_zero(input logic [63:0] x);
    return x[62:0] == 63'd0;
  endfunction

  function automatic logic [1:0] f_row_type(input logic is_obj, input logic eq);
    if (is_obj) return TYPE_OBJ;
    return eq ? TYPE_EQ : TYPE_INEQ;
  endfunction

endpackage

>>> hdl/nvrs_ram.sv
`timescale 1ns / 1ps
// nvrs_ram: generic single write port, single read port RAM with registered read.
// No dependencies.

module nvrs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> hdl/nvrs_front.sv
`timescale 1ns / 1ps
// nvrs_front: request intake, classification and two-entry queue to the back end.
// Also holds the objective index register. Depends on nvrs_pkg.

module nvrs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  nvrs_pkg::in_item_t in_data,
  input  logic               cfg_write,
  input  logic [9:0]         cfg_data,
  input  logic               hold,
  input  logic               q_pop,
  output logic               q_empty,
  output nvrs_pkg::q_entry_t q_data
);

  logic [9:0]            objective;
  nvrs_pkg::q_entry_t    q_mem [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  accept;
  nvrs_pkg::item_class_t cls;

  assign full    = (count == 2'd2) || hold;
  assign accept  = push && !full;
  assign q_empty = (count == 2'd0);
  assign q_data  = q_mem[rd_ptr];

  always_comb begin
    cls.var_ok = {7'd0, in_data.item_index} < 17'(nvrs_pkg::MAX_VARS);
    cls.row_ok = {7'd0, in_data.item_index} < 17'(nvrs_pkg::MAX_ROWS);
    cls.col_ok = {7'd0, in_data.col_index} < 17'(nvrs_pkg::MAX_VARS);
    cls.is_obj = in_data.item_index == objective;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      objective <= 10'd0;
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      count     <= 2'd0;
    end else begin
      if (cfg_write) objective <= cfg_data;
      if (accept) wr_ptr <= !wr_ptr;
      if (q_pop && !q_empty) rd_ptr <= !rd_ptr;
      case ({accept, q_pop && !q_empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem[wr_ptr] <= '{item: in_data, cls: cls};
    end
  end

endmodule

>>> hdl/nvrs_fpu.sv
`timescale 1ns / 1ps
// nvrs_fpu: iterative IEEE double subtract, multiply and divide, round to nearest even.
// One bit per cycle in alignment, multiply, divide and normalisation. Depends on nvrs_pkg.

module nvrs_fpu (
  input  logic               clk,
  input  logic               rst,
  input  nvrs_pkg::fpu_req_t req,
  output nvrs_pkg::fpu_rsp_t rsp
);

  localparam logic [2:0] F_IDLE    = 3'd0;
  localparam logic [2:0] F_ALIGN   = 3'd1;
  localparam logic [2:0] F_ADD     = 3'd2;
  localparam logic [2:0] F_PRENORM = 3'd3;
  localparam logic [2:0] F_MUL     = 3'd4;
  localparam logic [2:0] F_DIV     = 3'd5;
  localparam logic [2:0] F_NORM    = 3'd6;
  localparam logic [2:0] F_ROUND   = 3'd7;

  logic [2:0]         state;
  logic [1:0]         op_r;
  logic               sgn;
  logic               eff_sub;
  logic signed [13:0] ex;
  logic signed [13:0] ea;
  logic signed [13:0] eb;
  logic [52:0]        ma;
  logic [52:0]        mb;
  logic [56:0]        m;
  logic [56:0]        y;
  logic [105:0]       acc;
  logic [55:0]        quo;
  logic [54:0]        rem;
  logic [10:0]        cnt;
  logic [63:0]        res;
  logic               done;

  // operand unpack and special cases
  logic [63:0] a_in, b_in, spec_val;
  logic [52:0] a_sig, b_sig;
  logic [10:0] a_exp, b_exp;
  logic        a_big, spec_hit, sxor;
  logic        na, nb, ia, ib, za, zb;

  always_comb begin
    a_in  = req.a;
    b_in  = (req.op == nvrs_pkg::FOP_SUB) ? {~req.b[63], req.b[62:0]} : req.b;
    a_sig = {|a_in[62:52], a_in[51:0]};
    b_sig = {|b_in[62:52], b_in[51:0]};
    a_exp = (a_in[62:52] == 11'd0) ? 11'd1 : a_in[62:52];
    b_exp = (b_in[62:52] == 11'd0) ? 11'd1 : b_in[62:52];
    a_big = a_in[62:0] >= b_in[62:0];
    sxor  = a_in[63] ^ b_in[63];
    na = nvrs_pkg::f_is_nan(a_in);
    nb = nvrs_pkg::f_is_nan(b_in);
    ia = nvrs_pkg::f_is_inf(a_in);
    ib = nvrs_pkg::f_is_inf(b_in);
    za = nvrs_pkg::f_is_zero(a_in);
    zb = nvrs_pkg::f_is_zero(b_in);
    spec_hit = 1'b0;
    spec_val = nvrs_pkg::QNAN_BITS;
    case (req.op)
      nvrs_pkg::FOP_SUB: begin
        if (na || nb) begin
          spec_hit = 1'b1;
        end else if (ia && ib) begin
          spec_hit = 1'b1;
          spec_val = (a_in[63] == b_in[63]) ? a_in : nvrs_pkg::QNAN_BITS;
        end else if (ia) begin
          spec_hit = 1'b1;
          spec_val = a_in;
        end else if (ib) begin
          spec_hit = 1'b1;
          spec_val = b_in;
        end
      end
      nvrs_pkg::FOP_MUL: begin
        if (na || nb || (ia && zb) || (za && ib)) begin
          spec_hit = 1'b1;
        end else if (ia || ib) begin
          spec_hit = 1'b1;
          spec_val = {sxor, 11'h7FF, 52'd0};
        end else if (za || zb) begin
          spec_hit = 1'b1;
          spec_val = {sxor, 63'd0};
        end
      end
      nvrs_pkg::FOP_DIV: begin
        if (na || nb || (ia && ib) || (za && zb)) begin
          spec_hit = 1'b1;
        end else if (ia || zb) begin
          spec_hit = 1'b1;
          spec_val = {sxor, 11'h7FF, 52'd0};
        end else if (ib || za) begin
          spec_hit = 1'b1;
          spec_val = {sxor, 63'd0};
        end
      end
      default: spec_hit = 1'b0;
    endcase
  end

  // rounding of the normalised significand
  logic               rup;
  logic [53:0]        mant54;
  logic [52:0]        mant53;
  logic signed [13:0] ex1;
  logic [63:0]        packed_res;

  always_comb begin
    rup    = m[2] & (m[1] | m[0] | m[3]);
    mant54 = {1'b0, m[55:3]} + {53'd0, rup};
    ex1    = mant54[53] ? ex + 14'sd1 : ex;
    mant53 = mant54[53] ? mant54[53:1] : mant54[52:0];
    if (ex1 >= 14'sd2047)
      packed_res = {sgn, 11'h7FF, 52'd0};
    else
      packed_res = {sgn, (mant53[52] ? ex1[10:0] : 11'd0), mant53[51:0]};
  end

  logic [56:0] sum;
  logic [53:0] psum;
  logic        ge;

  always_comb begin
    sum  = eff_sub ? (m - y) : (m + y);
    psum = {1'b0, acc[105:53]} + {1'b0, (mb[0] ? ma : 53'd0)};
    ge   = rem >= {2'b00, mb};
  end

  assign rsp.done = done;
  assign rsp.res  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      // special operands answer straight from idle, everything else after rounding
      done <= (state == F_IDLE && req.start && spec_hit) || (state == F_ROUND);
      case (state)
        F_IDLE: begin
          if (req.start) begin
            op_r <= req.op;
            if (spec_hit) begin
              res <= spec_val;
            end else if (req.op == nvrs_pkg::FOP_SUB) begin
              sgn     <= a_big ? a_in[63] : b_in[63];
              eff_sub <= sxor;
              m       <= {1'b0, (a_big ? a_sig : b_sig), 3'd0};
              y       <= {1'b0, (a_big ? b_sig : a_sig), 3'd0};
              cnt     <= a_big ? (a_exp - b_exp) : (b_exp - a_exp);
              ex      <= $signed({3'd0, (a_big ? a_exp : b_exp)});
              state   <= F_ALIGN;
            end else begin
              sgn   <= sxor;
              ma    <= a_sig;
              mb    <= b_sig;
              ea    <= $signed({3'd0, a_exp});
              eb    <= $signed({3'd0, b_exp});
              state <= F_PRENORM;
            end
          end
        end
        F_ALIGN: begin
          if (cnt == 11'd0 || y[56:1] == 56'd0) begin
            state <= F_ADD;
          end else begin
            y   <= {1'b0, y[56:2], y[1] | y[0]};
            cnt <= cnt - 11'd1;
          end
        end
        F_ADD: begin
          m <= sum;
          if (eff_sub && sum == 57'd0) sgn <= 1'b0;  // exact cancellation gives +0
          state <= F_NORM;
        end
        F_PRENORM: begin
          if (ma[52] && mb[52]) begin
            if (op_r == nvrs_pkg::FOP_MUL) begin
              acc   <= '0;
              cnt   <= 11'd53;
              state <= F_MUL;
            end else begin
              rem   <= {2'b00, ma};
              quo   <= '0;
              cnt   <= 11'd56;
              state <= F_DIV;
            end
          end else begin
            if (!ma[52]) begin
              ma <= {ma[51:0], 1'b0};
              ea <= ea - 14'sd1;
            end
            if (!mb[52]) begin
              mb <= {mb[51:0], 1'b0};
              eb <= eb - 14'sd1;
            end
          end
        end
        F_MUL: begin
          if (cnt == 11'd0) begin
            m     <= {acc[105:50], |acc[49:0]};
            ex    <= ea + eb - 14'sd1023;
            state <= F_NORM;
          end else begin
            acc <= {psum, acc[52:1]};
            mb  <= {1'b0, mb[52:1]};
            cnt <= cnt - 11'd1;
          end
        end
        F_DIV: begin
          if (cnt == 11'd0) begin
            m     <= {quo, |rem};
            ex    <= ea - eb + 14'sd1022;
            state <= F_NORM;
          end else begin
            rem <= ge ? {54'(rem - {2'b00, mb}), 1'b0} : {rem[53:0], 1'b0};
            quo <= {quo[54:0], ge};
            cnt <= cnt - 11'd1;
          end
        end
        F_NORM: begin
          if (m[56] || ex < 14'sd1) begin
            if (!m[56] && m[56:1] == 56'd0) begin
              ex <= 14'sd1;  // only sticky left: jump to the subnormal exponent
            end else begin
              m  <= {1'b0, m[56:2], m[1] | m[0]};
              ex <= ex + 14'sd1;
            end
          end else if (!m[55] && ex > 14'sd1 && m != 57'd0) begin
            m  <= {m[55:0], 1'b0};
            ex <= ex - 14'sd1;
          end else begin
            state <= F_ROUND;
          end
        end
        F_ROUND: begin
          res   <= packed_res;
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/nvrs_back.sv
`timescale 1ns / 1ps
// nvrs_back: sequencer that carries out queued requests against the gain stores.
// Uses nvrs_fpu and nvrs_ram; depends on nvrs_pkg.

module nvrs_back (
  input  logic                clk,
  input  logic                rst,
  output logic                hold,
  input  logic                q_empty,
  input  nvrs_pkg::q_entry_t  q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output nvrs_pkg::out_item_t out_data
);

  localparam int VAW = nvrs_pkg::VAR_AW;
  localparam int RAW = nvrs_pkg::ROW_AW;

  localparam logic [2:0] B_CLEAR = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_READ  = 3'd2;
  localparam logic [2:0] B_SUB   = 3'd3;
  localparam logic [2:0] B_DIV   = 3'd4;
  localparam logic [2:0] B_MUL   = 3'd5;
  localparam logic [2:0] B_JAC   = 3'd6;
  localparam logic [2:0] B_OUT   = 3'd7;

  logic [2:0]          state;
  logic [RAW-1:0]      clr_cnt;
  nvrs_pkg::q_entry_t  cur;
  logic                eq_r;
  logic [63:0]         gain_r;
  nvrs_pkg::out_item_t res;
  logic                out_valid;

  nvrs_pkg::fpu_req_t  freq;
  nvrs_pkg::fpu_rsp_t  frsp;

  logic                var_we;
  logic [63:0]         var_rdata;
  logic                row_we;
  logic [RAW-1:0]      row_waddr;
  logic [64:0]         row_wdata;
  logic [64:0]         row_rdata;

  logic                row_eq_rd;
  logic [63:0]         row_gain_rd;
  logic                sub_eq;
  logic [63:0]         cand;
  logic                repl;

  nvrs_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (freq),
    .rsp (frsp)
  );

  nvrs_ram #(.WIDTH(64), .DEPTH(nvrs_pkg::MAX_VARS)) u_var_ram (
    .clk   (clk),
    .we    (var_we),
    .waddr (VAW'(cur.item.item_index)),
    .wdata (frsp.res),
    .re    (q_pop),
    .raddr (VAW'(q_data.item.col_index)),
    .rdata (var_rdata)
  );

  // row store entry: {equality flag, gain}
  nvrs_ram #(.WIDTH(65), .DEPTH(nvrs_pkg::MAX_ROWS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (q_pop),
    .raddr (RAW'(q_data.item.item_index)),
    .rdata (row_rdata)
  );

  assign hold  = (state == B_CLEAR);
  assign q_pop = (state == B_IDLE) && !q_empty;
  assign empty = !out_valid;

  always_comb begin
    row_eq_rd   = cur.cls.row_ok && row_rdata[64];
    row_gain_rd = cur.cls.row_ok ? row_rdata[63:0] : nvrs_pkg::ONE_BITS;
    sub_eq      = !nvrs_pkg::f_is_nan(frsp.res) &&
                  (frsp.res[62:0] < nvrs_pkg::EPS_BITS[62:0]);
    cand        = {1'b0, frsp.res[62:0]};
    repl        = !nvrs_pkg::f_is_nan(cand) && (cand > gain_r);
  end

  always_comb begin
    freq      = '0;
    var_we    = 1'b0;
    row_we    = 1'b0;
    row_waddr = RAW'(cur.item.item_index);
    row_wdata = {1'b0, nvrs_pkg::ONE_BITS};
    case (state)
      B_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = clr_cnt;
      end
      B_READ: begin
        if (cur.item.op == nvrs_pkg::OP_VAR || cur.item.op == nvrs_pkg::OP_ROW) begin
          freq.start = 1'b1;
          freq.op    = nvrs_pkg::FOP_SUB;
          freq.a     = cur.item.upper_bits;
          freq.b     = cur.item.lower_bits;
        end else if (cur.item.op == nvrs_pkg::OP_JAC && row_eq_rd && cur.cls.col_ok) begin
          freq.start = 1'b1;
          freq.op    = nvrs_pkg::FOP_DIV;
          freq.a     = cur.item.jac_value;
          freq.b     = var_rdata;
        end
      end
      B_SUB: begin
        if (frsp.done) begin
          if (cur.item.op == nvrs_pkg::OP_VAR) begin
            freq.start = 1'b1;
            freq.op    = nvrs_pkg::FOP_DIV;
            freq.a     = nvrs_pkg::ONE_BITS;
            freq.b     = frsp.res;
          end else begin
            row_we    = cur.cls.row_ok;
            row_wdata = {sub_eq, (sub_eq ? 64'd0 : nvrs_pkg::ONE_BITS)};
          end
        end
      end
      B_DIV: begin
        if (frsp.done) begin
          var_we     = cur.cls.var_ok;
          freq.start = 1'b1;
          freq.op    = nvrs_pkg::FOP_MUL;
          freq.a     = {~cur.item.lower_bits[63], cur.item.lower_bits[62:0]};
          freq.b     = frsp.res;
        end
      end
      B_JAC: begin
        if (frsp.done && repl) begin
          row_we    = 1'b1;
          row_wdata = {1'b1, cand};
        end
      end
      default: freq = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == B_OUT && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == RAW'(nvrs_pkg::MAX_ROWS - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (q_pop) state <= B_READ;
        end
        B_READ: begin
          eq_r   <= row_eq_rd;
          gain_r <= row_gain_rd;
          case (cur.item.op)
            nvrs_pkg::OP_VAR, nvrs_pkg::OP_ROW: begin
              res   <= '0;
              state <= B_SUB;
            end
            nvrs_pkg::OP_JAC: begin
              if (row_eq_rd && cur.cls.col_ok) begin
                res   <= '0;
                state <= B_JAC;
              end else begin
                res   <= '{64'd0, 64'd0,
                           nvrs_pkg::f_row_type(cur.cls.is_obj, row_eq_rd), row_gain_rd};
                state <= B_OUT;
              end
            end
            default: begin
              res   <= '{64'd0, 64'd0,
                         nvrs_pkg::f_row_type(cur.cls.is_obj, row_eq_rd), row_gain_rd};
              state <= B_OUT;
            end
          endcase
        end
        B_SUB: begin
          if (frsp.done) begin
            if (cur.item.op == nvrs_pkg::OP_VAR) begin
              state <= B_DIV;
            end else begin
              res   <= '{64'd0, 64'd0, nvrs_pkg::f_row_type(cur.cls.is_obj, sub_eq),
                         (sub_eq ? 64'd0 : nvrs_pkg::ONE_BITS)};
              state <= B_OUT;
            end
          end
        end
        B_DIV: begin
          if (frsp.done) begin
            res.var_gain <= frsp.res;
            state        <= B_MUL;
          end
        end
        B_MUL: begin
          if (frsp.done) begin
            res.var_offset <= frsp.res;
            state          <= B_OUT;
          end
        end
        B_JAC: begin
          if (frsp.done) begin
            res   <= '{64'd0, 64'd0, nvrs_pkg::f_row_type(cur.cls.is_obj, eq_r),
                       (repl ? cand : gain_r)};
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_valid || pop) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
    if (state == B_OUT && (!out_valid || pop)) out_data <= res;
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == B_CLEAR) |-> !q_pop)
    else $error("queue popped during clearing pass");

  a_fpu_done_expected: assert property (@(posedge clk) disable iff (rst)
    frsp.done |-> (state == B_SUB || state == B_DIV || state == B_MUL || state == B_JAC))
    else $error("fpu result arrived with no operation waiting");

  a_row_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (row_we && state != B_CLEAR) |-> cur.cls.row_ok)
    else $error("row store written for an out-of-range row");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT && (!out_valid || pop)) |=> (out_valid && state == B_IDLE))
    else $error("result not loaded into output register");

endmodule

>>> hdl/nlp_variable_and_row_scaler_core.sv
`timescale 1ns / 1ps
// nlp_variable_and_row_scaler_core: top level of the variable and row scaler.
// Instantiates nvrs_front and nvrs_back; depends on nvrs_pkg.

// Scales an optimisation problem in IEEE double precision. Each request gives one
// result, in order. Op 0 (variable bounds) returns gain 1/(upper-lower) and offset
// -lower*gain and stores the gain; op 1 (row bounds) classifies the row as equality
// (|upper-lower| < 1e-8, gain 0) or inequality (gain 1.0); op 2 (Jacobian entry)
// raises an equality row's gain to |value/gain[column]| when larger; op 3 reads a row.
// A row equal to objective_index reads as type objective. NaN results come out as
// the quiet NaN 0x7FF8000000000000. Variable bounds must be loaded before Jacobian
// entries that use them. Requests are taken into a two-entry queue and carried out
// one at a time on a single iterative floating point unit that handles one bit per
// cycle in alignment, multiplication, division and normalisation. Op 0 runs a
// subtract, a divide and a multiply in turn; a step whose operands are zero,
// infinite or NaN is answered straight from the unit's idle state. After reset the
// row store is cleared, during which full stays high; configuration writes are
// taken at any time and should be made only while no request is in flight.

module nlp_variable_and_row_scaler_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  nvrs_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output nvrs_pkg::out_item_t out_data,
  input  logic                cfg_write,
  input  logic [9:0]          cfg_data
);

  // back end holds off intake while the row store is being cleared
  logic               hold;
  logic               q_empty;
  logic               q_pop;
  nvrs_pkg::q_entry_t q_data;

  // front: intake, classification (range checks, objective match) and queue
  nvrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .hold      (hold),
    .q_pop     (q_pop),
    .q_empty   (q_empty),
    .q_data    (q_data)
  );

  // back: sequencer, floating point unit, gain stores and output register
  nvrs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .hold     (hold),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for nlp_variable_and_row_scaler_core; a scoreboard predicts gains,
// offsets and row types in double precision. Depends on nvrs_pkg and the core RTL.

module tb;
  import nvrs_pkg::*;

  localparam int      CYCLE_LIMIT = 2000000;
  localparam int      SETTLE      = 600;   // longer than the slowest request
  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] INF_BITS = 64'h7FF0_0000_0000_0000;

  // Holds its own copy of the scaler state and the queue of predicted results.
  class scale_scoreboard;
    logic [63:0] var_gain_mem [MAX_VARS];
    bit          var_loaded   [MAX_VARS];
    int          loaded_cols  [$];
    bit          row_eq       [MAX_ROWS];
    logic [63:0] row_gain_mem [MAX_ROWS];
    logic [9:0]  objective;
    out_item_t   predicted_q  [$];
    int          errors;
    int          checked;

    function new();
      foreach (row_gain_mem[i]) begin
        row_gain_mem[i] = ONE_BITS;
        row_eq[i]       = 1'b0;
      end
      foreach (var_loaded[i]) var_loaded[i] = 1'b0;
      objective = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    function bit nan_bits(logic [63:0] b);
      return (&b[62:52]) && (|b[51:0]);
    endfunction

    function logic [63:0] canon(real r);
      logic [63:0] b;
      b = $realtobits(r);
      return nan_bits(b) ? QNAN_BITS : b;
    endfunction

    // IEEE quotient with explicit handling of a zero divisor
    function logic [63:0] quotient(logic [63:0] a, logic [63:0] b);
      if (b[62:0] == 63'd0) begin
        if (nan_bits(a) || a[62:0] == 63'd0) return QNAN_BITS;
        return INF_BITS | ((a ^ b) & SIGN_BIT);
      end
      return canon($bitstoreal(a) / $bitstoreal(b));
    endfunction

    function void note(in_item_t it);
      out_item_t   e;
      logic [63:0] g, d, cand;
      bit          eq;
      e = '0;
      if (it.op == OP_VAR) begin
        g = quotient(ONE_BITS, canon($bitstoreal(it.upper_bits) - $bitstoreal(it.lower_bits)));
        var_gain_mem[it.item_index] = g;
        if (!var_loaded[it.item_index])
          loaded_cols.insert(loaded_cols.size(), int'(it.item_index));
        var_loaded[it.item_index] = 1'b1;
        e.var_gain   = g;
        e.var_offset = canon(-$bitstoreal(it.lower_bits) * $bitstoreal(g));
      end else begin
        if (it.op == OP_ROW) begin
          d  = canon($bitstoreal(it.upper_bits) - $bitstoreal(it.lower_bits));
          eq = !nan_bits(d) && ($bitstoreal(d & ~SIGN_BIT) < 1.0e-8);
          row_eq[it.item_index]       = eq;
          row_gain_mem[it.item_index] = eq ? 64'd0 : ONE_BITS;
        end else if (it.op == OP_JAC && row_eq[it.item_index]) begin
          cand = quotient(it.jac_value, var_gain_mem[it.col_index]) & ~SIGN_BIT;
          if (!nan_bits(cand) &&
              $bitstoreal(cand) > $bitstoreal(row_gain_mem[it.item_index]))
            row_gain_mem[it.item_index] = cand;
        end
        eq         = row_eq[it.item_index];
        e.row_type = (it.item_index == objective) ? TYPE_OBJ : (eq ? TYPE_EQ : TYPE_INEQ);
        e.row_gain = row_gain_mem[it.item_index];
      end
      predicted_q.insert(predicted_q.size(), e);
    endfunction

    function void check(out_item_t got);
      out_item_t e;
      if (predicted_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = predicted_q.pop_front();
      checked++;
      if (got.var_gain !== e.var_gain) begin
        $display("%0t: var_gain exp %h got %h", $time, e.var_gain, got.var_gain);
        errors++;
      end
      if (got.var_offset !== e.var_offset) begin
        $display("%0t: var_offset exp %h got %h", $time, e.var_offset, got.var_offset);
        errors++;
      end
      if (got.row_type !== e.row_type) begin
        $display("%0t: row_type exp %0d got %0d", $time, e.row_type, got.row_type);
        errors++;
      end
      if (got.row_gain !== e.row_gain) begin
        $display("%0t: row_gain exp %h got %h", $time, e.row_gain, got.row_gain);
        errors++;
      end
    endfunction

    function int pending();
      return predicted_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_data = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_data;
  logic      cfg_write = 1'b0;
  logic [9:0] cfg_data = '0;

  scale_scoreboard sb = new();
  int cycles    = 0;
  int send_idle = 0;   // percent of cycles the sender stays quiet
  int rx_stall  = 0;   // percent of cycles the receiver refuses
  int hold_left = 0;   // long receiver hold-off, counted down below
  int sent      = 0;

  nlp_variable_and_row_scaler_core dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: check on every accepted pop, then pick the next pop value
  always @(posedge clk) begin
    if (pop && !empty) sb.check(out_data);
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_stall);
    end
  end

  function automatic in_item_t mk(logic [1:0] op, logic [9:0] idx, logic [9:0] col,
                                  logic [63:0] lo, logic [63:0] hi, logic [63:0] val);
    in_item_t it;
    it = '{op, idx, col, lo, hi, val};
    return it;
  endfunction

  function automatic logic [63:0] rand_double();
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return $realtobits((real'($urandom_range(2000)) - 1000.0) / 8.0);
      2: return $realtobits(real'($urandom) * 1.0e-6 - 2000.0);
      default: begin
        case ($urandom_range(5))
          0: return 64'd0;
          1: return SIGN_BIT;
          2: return INF_BITS;
          3: return INF_BITS | SIGN_BIT;
          4: return QNAN_BITS;
          default: return ONE_BITS;
        endcase
      end
    endcase
  endfunction

  // mostly few hot rows so Jacobian entries land on equality rows
  function automatic in_item_t rand_request();
    in_item_t    it;
    logic [63:0] lo;
    int          pick;
    it.op         = OP_READ;
    it.col_index  = 10'($urandom);
    it.lower_bits = {$urandom, $urandom};
    it.upper_bits = {$urandom, $urandom};
    it.jac_value  = {$urandom, $urandom};
    it.item_index = ($urandom_range(9) < 8) ? 10'($urandom_range(31)) : 10'($urandom);
    pick = $urandom_range(99);
    if (pick < 15) begin
      it.op         = OP_VAR;
      it.lower_bits = rand_double();
      it.upper_bits = rand_double();
    end else if (pick < 40) begin
      it.op = OP_ROW;
      lo    = rand_double();
      it.lower_bits = lo;
      case ($urandom_range(3))
        0: it.upper_bits = lo;
        1: it.upper_bits = $realtobits($bitstoreal(lo) + 1.0e-9);
        default: it.upper_bits = rand_double();
      endcase
    end else if (pick < 75 && sb.loaded_cols.size() > 0) begin
      it.op        = OP_JAC;
      it.col_index = 10'(sb.loaded_cols[$urandom_range(sb.loaded_cols.size() - 1)]);
      it.jac_value = rand_double();
    end else begin
      it.op = OP_READ;
    end
    return it;
  endfunction

  // holds push high until the request is taken; lowers it for random idle gaps, else the caller lowers it
  task automatic send_request(in_item_t it);
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    sb.note(it);
    sent++;
    if ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      while ($urandom_range(99) < send_idle) @(posedge clk);
      @(posedge clk);
    end
  endtask

  task automatic drain_and_configure(logic [9:0] obj);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= obj;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.objective = obj;
  endtask

  task automatic random_phase(logic [9:0] obj, int s_idle, int r_stall, int hold, int n);
    drain_and_configure(obj);
    send_idle = s_idle;
    rx_stall  = r_stall;
    hold_left = hold;
    repeat (n) send_request(rand_request());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    drain_and_configure(10'd0);

    // directed: bound extremes, zero divisors, NaNs, ignored and applied Jacobian entries
    send_request(mk(OP_VAR,  10'd0,    10'd0, 64'd0, ONE_BITS, 64'd0));
    send_request(mk(OP_VAR,  10'd1,    10'd0, $realtobits(-2.0), $realtobits(2.0), 64'd0));
    send_request(mk(OP_VAR,  10'd2,    10'd0, 64'd0, 64'd0, 64'd0));
    send_request(mk(OP_VAR,  10'd3,    10'd0, '1, 64'd0, 64'd0));
    send_request(mk(OP_VAR,  10'd4,    10'd0, INF_BITS | SIGN_BIT, INF_BITS, 64'd0));
    send_request(mk(OP_VAR,  10'd5,    10'd0, ONE_BITS, $realtobits(0.5), 64'd0));
    send_request(mk(OP_VAR,  10'd1023, 10'd0, $realtobits(-3.0), $realtobits(5.0), 64'd0));
    send_request(mk(OP_ROW,  10'd0,    10'd0, $realtobits(3.0), $realtobits(3.0), 64'd0));
    send_request(mk(OP_ROW,  10'd1023, 10'd0, 64'd0, $realtobits(1.0e-9), 64'd0));
    send_request(mk(OP_ROW,  10'd7,    10'd0, 64'd0, ONE_BITS, 64'd0));
    send_request(mk(OP_ROW,  10'd8,    10'd0, QNAN_BITS, ONE_BITS, 64'd0));
    send_request(mk(OP_ROW,  10'd9,    10'd0, INF_BITS, INF_BITS, 64'd0));
    send_request(mk(OP_JAC,  10'd1023, 10'd1, 64'd0, 64'd0, $realtobits(8.0)));
    send_request(mk(OP_JAC,  10'd1023, 10'd0, 64'd0, 64'd0, $realtobits(-1.0)));
    send_request(mk(OP_JAC,  10'd1023, 10'd4, 64'd0, 64'd0, ONE_BITS));
    send_request(mk(OP_JAC,  10'd0,    10'd2, 64'd0, 64'd0, 64'd0));
    send_request(mk(OP_JAC,  10'd0,    10'd3, 64'd0, 64'd0, $realtobits(5.0)));
    send_request(mk(OP_JAC,  10'd7,    10'd1, 64'd0, 64'd0, $realtobits(100.0)));
    send_request(mk(OP_JAC,  10'd0,    10'd4, 64'd0, 64'd0, 64'd0));
    send_request(mk(OP_JAC,  10'd0,    10'd5, 64'd0, 64'd0, '1));
    send_request(mk(OP_JAC,  10'd0,    10'd1023, '1, '1, $realtobits(-3.0)));
    send_request(mk(OP_READ, 10'd1023, 10'd0, 64'd0, 64'd0, 64'd0));
    send_request(mk(OP_READ, 10'd0,    10'd0, 64'd0, 64'd0, 64'd0));
    send_request(mk(OP_READ, 10'd500,  10'd0, 64'd0, 64'd0, 64'd0));

    random_phase(10'd1023,               0,  0,    0, 120);
    random_phase(10'($urandom_range(31)), 79, 0,    0, 120);
    random_phase(10'd5,                  0,  79,   0, 120);
    random_phase(10'($urandom),           23, 23,   0, 120);
    random_phase(10'd0,                  0,  0, 3000, 120);

    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d requests over six phases (directed, back-to-back, idle sender,",
             sent);
    $display("stalled receiver, mixed, long hold-off); %0d results checked, %0d errors",
             sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
